FILE: design/masseq_pkg.sv
// Shared types and constants for the mux ADC scan sequencer.
`default_nettype none

package masseq_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 12;

  localparam int CH_W      = 3;
  localparam int SAMPLE_W  = 12;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Saturation value of the settle and conversion counters.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Channel numbers at or above this limit are rejected.
  localparam logic [CH_W:0] CHANNEL_LIMIT = (CH_W + 1)'(CHANNELS);

  // Bits of the converter sample that are kept when it is latched.
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                              : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OPC_TICK    = 3'd0,
    OPC_PREPARE = 3'd1,
    OPC_START   = 3'd2,
    OPC_DONE    = 3'd3,
    OPC_TAKE    = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    K_TICK,
    K_PREPARE,
    K_START,
    K_DONE,
    K_TAKE,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE_TICKS  = 2'd0,
    REG_CONV_TIMEOUT  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    kind_t                kind;
    logic                 ch_ok;    // channel below the channel count
    logic                 pair_ok;  // channel and next channel both in range
    logic [CH_W-1:0]      ch;
    logic [CH_W-1:0]      nxt;
    logic [SAMPLE_W-1:0]  sample;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/masseq_front.sv
// Front end: decodes an incoming item into a classified command.
`default_nettype none

module masseq_front (
  input  wire logic [2:0]                   opcode,
  input  wire logic [masseq_pkg::CH_W-1:0]  channel,
  input  wire logic [masseq_pkg::CH_W-1:0]  follow_channel,
  input  wire logic [masseq_pkg::SAMPLE_W-1:0] adc_sample,
  output masseq_pkg::cmd_t                  cmd
);

  logic ch_ok;
  logic nxt_ok;

  assign ch_ok  = {1'b0, channel} < masseq_pkg::CHANNEL_LIMIT;
  assign nxt_ok = {1'b0, follow_channel} < masseq_pkg::CHANNEL_LIMIT;

  always_comb begin
    cmd.ch      = channel;
    cmd.nxt     = follow_channel;
    cmd.sample  = adc_sample & masseq_pkg::SAMPLE_MASK;
    cmd.ch_ok   = ch_ok;
    cmd.pair_ok = ch_ok && nxt_ok;
    case (opcode)
      masseq_pkg::OPC_TICK:    cmd.kind = masseq_pkg::K_TICK;
      masseq_pkg::OPC_PREPARE: cmd.kind = masseq_pkg::K_PREPARE;
      masseq_pkg::OPC_START:   cmd.kind = masseq_pkg::K_START;
      masseq_pkg::OPC_DONE:    cmd.kind = masseq_pkg::K_DONE;
      masseq_pkg::OPC_TAKE:    cmd.kind = masseq_pkg::K_TAKE;
      default:                 cmd.kind = masseq_pkg::K_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/masseq_queue.sv
// Short command queue between the front end and the execution back end.
`default_nettype none

module masseq_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire masseq_pkg::cmd_t  push_cmd,
  output logic                   head_valid,
  output masseq_pkg::cmd_t       head_cmd,
  input  wire logic              pop
);

  masseq_pkg::cmd_t                entries [masseq_pkg::QUEUE_DEPTH];
  logic [masseq_pkg::QPTR_W-1:0]   wr_ptr;
  logic [masseq_pkg::QPTR_W-1:0]   rd_ptr;
  logic [masseq_pkg::QCNT_W-1:0]   count;
  logic                            push;
  logic                            do_pop;

  assign push_ready = count != masseq_pkg::QCNT_W'(masseq_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  function automatic logic [masseq_pkg::QPTR_W-1:0] bump(
    input logic [masseq_pkg::QPTR_W-1:0] p
  );
    if (p == masseq_pkg::QPTR_W'(masseq_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/masseq_back.sv
// Back end: sequencer state, configuration registers and the result register.
`default_nettype none

module masseq_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              head_valid,
  input  wire masseq_pkg::cmd_t                  head_cmd,
  output logic                                   pop,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [masseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [masseq_pkg::COUNT_W-1:0]    cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             status,
  output logic                                   result_valid,
  output logic [masseq_pkg::CH_W-1:0]            taken_channel,
  output logic [masseq_pkg::SAMPLE_W-1:0]        result_sample,
  output logic [masseq_pkg::CH_W-1:0]            mux_select,
  output logic                                   start_pulse,
  output logic                                   stop_pulse
);

  logic [masseq_pkg::COUNT_W-1:0]  settle_ticks;
  logic [masseq_pkg::COUNT_W-1:0]  timeout_ticks;

  logic [masseq_pkg::CH_W-1:0]     sel_channel, sel_channel_next;
  logic [masseq_pkg::COUNT_W-1:0]  settle_count, settle_count_next;
  logic                            conv_active, conv_active_next;
  logic [masseq_pkg::CH_W-1:0]     conv_channel, conv_channel_next;
  logic [masseq_pkg::CH_W-1:0]     preselect_channel, preselect_channel_next;
  logic [masseq_pkg::COUNT_W-1:0]  conv_count, conv_count_next;
  logic                            result_held, result_held_next;
  logic [masseq_pkg::CH_W-1:0]     latched_channel, latched_channel_next;
  logic [masseq_pkg::SAMPLE_W-1:0] latched_sample, latched_sample_next;

  masseq_pkg::status_t             st_now;
  logic                            valid_now;
  logic [masseq_pkg::CH_W-1:0]     rch_now;
  logic [masseq_pkg::SAMPLE_W-1:0] rsmp_now;
  logic                            start_now;
  logic                            stop_now;
  logic [masseq_pkg::COUNT_W-1:0]  settle_after_sel;

  function automatic logic [masseq_pkg::COUNT_W-1:0] sat_inc(
    input logic [masseq_pkg::COUNT_W-1:0] v
  );
    return (v == masseq_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;
  assign pop       = head_valid && (!out_valid || out_ready);

  always_comb begin
    sel_channel_next       = sel_channel;
    settle_count_next      = settle_count;
    conv_active_next       = conv_active;
    conv_channel_next      = conv_channel;
    preselect_channel_next = preselect_channel;
    conv_count_next        = conv_count;
    result_held_next       = result_held;
    latched_channel_next   = latched_channel;
    latched_sample_next    = latched_sample;
    st_now                 = masseq_pkg::ST_OK;
    valid_now              = 1'b0;
    rch_now                = '0;
    rsmp_now               = '0;
    start_now              = 1'b0;
    stop_now               = 1'b0;
    // Settle count as seen after a start selects its channel.
    settle_after_sel       = (sel_channel != head_cmd.ch) ? '0 : settle_count;

    case (head_cmd.kind)
      masseq_pkg::K_TICK: begin
        settle_count_next = sat_inc(settle_count);
        if (conv_active) begin
          conv_count_next = sat_inc(conv_count);
        end
      end
      masseq_pkg::K_PREPARE: begin
        if (!head_cmd.ch_ok) begin
          st_now = masseq_pkg::ST_INVALID;
        end else if (sel_channel != head_cmd.ch) begin
          sel_channel_next  = head_cmd.ch;
          settle_count_next = '0;
        end
      end
      masseq_pkg::K_START: begin
        if (!head_cmd.pair_ok) begin
          st_now = masseq_pkg::ST_INVALID;
        end else if (conv_active || result_held) begin
          st_now = masseq_pkg::ST_BUSY;
        end else begin
          sel_channel_next  = head_cmd.ch;
          settle_count_next = settle_after_sel;
          if (settle_after_sel < settle_ticks) begin
            st_now = masseq_pkg::ST_BUSY;
          end else begin
            conv_channel_next      = head_cmd.ch;
            preselect_channel_next = head_cmd.nxt;
            conv_count_next        = '0;
            conv_active_next       = 1'b1;
            start_now              = 1'b1;
          end
        end
      end
      masseq_pkg::K_DONE: begin
        if (conv_active) begin
          latched_sample_next  = head_cmd.sample;
          latched_channel_next = conv_channel;
          sel_channel_next     = preselect_channel;
          settle_count_next    = '0;
          conv_active_next     = 1'b0;
          result_held_next     = 1'b1;
        end
      end
      masseq_pkg::K_TAKE: begin
        if (result_held) begin
          valid_now        = 1'b1;
          rch_now          = latched_channel;
          rsmp_now         = latched_sample;
          result_held_next = 1'b0;
        end else if (conv_active && (conv_count >= timeout_ticks)) begin
          conv_active_next = 1'b0;
          stop_now         = 1'b1;
          st_now           = masseq_pkg::ST_TIMEOUT;
        end else begin
          st_now = masseq_pkg::ST_BUSY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks      <= '0;
      timeout_ticks     <= masseq_pkg::COUNT_W'(1000);
      sel_channel       <= '0;
      settle_count      <= '0;
      conv_active       <= 1'b0;
      conv_channel      <= '0;
      preselect_channel <= '0;
      conv_count        <= '0;
      result_held       <= 1'b0;
      latched_channel   <= '0;
      latched_sample    <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          masseq_pkg::REG_SETTLE_TICKS: settle_ticks  <= cfg_data;
          masseq_pkg::REG_CONV_TIMEOUT: timeout_ticks <= cfg_data;
          default: begin
          end
        endcase
      end
      if (pop) begin
        sel_channel       <= sel_channel_next;
        settle_count      <= settle_count_next;
        conv_active       <= conv_active_next;
        conv_channel      <= conv_channel_next;
        preselect_channel <= preselect_channel_next;
        conv_count        <= conv_count_next;
        result_held       <= result_held_next;
        latched_channel   <= latched_channel_next;
        latched_sample    <= latched_sample_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status        <= st_now;
      result_valid  <= valid_now;
      taken_channel <= rch_now;
      result_sample <= rsmp_now;
      mux_select    <= sel_channel_next;
      start_pulse   <= start_now;
      stop_pulse    <= stop_now;
    end
  end

`ifndef SYNTHESIS
  a_conv_xor_ready: assert property (@(posedge clk) disable iff (rst)
    !(conv_active && result_held))
    else $error("conversion pending while an unread result is held");

  a_start_sets_active: assert property (@(posedge clk) disable iff (rst)
    (pop && start_now) |=> conv_active)
    else $error("started conversion is not marked active");

  a_stop_is_timeout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stop_pulse) |->
      (status == masseq_pkg::ST_TIMEOUT && !result_valid && !start_pulse))
    else $error("stop item carries inconsistent status");

  a_valid_means_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_valid) |-> (status == masseq_pkg::ST_OK))
    else $error("returned result without ok status");

  a_take_clears_ready: assert property (@(posedge clk) disable iff (rst)
    (pop && valid_now) |=> !result_held)
    else $error("taken result still marked ready");
`endif

endmodule

`default_nettype wire

FILE: design/mux_adc_scan_sequencer.sv
// Top level of the mux ADC scan sequencer.
`default_nettype none

// The sequencer drives the three select lines of an analog multiplexer in front
// of an ADC and gates conversion starts on settling time, pending conversions
// and unread results. Every item on the input channel (tick, prepare, start,
// adc done, take) produces exactly one result item carrying the status, any
// returned sample, the select value after the item and the start and stop
// pulses. While the output is not stalled, the block sustains one item per
// clock cycle in both directions: a front decoder classifies each accepted
// item into a two-entry command queue, and the back end applies one queued
// command per cycle to its state while the output register is free or being
// read, and writes the result into that output register; the queue and output
// register let either side stall without losing throughput on the other.
// Configuration writes to settle_ticks (index 0) and conversion_timeout_ticks
// (index 1) are taken in every cycle and must be issued only while no item is
// in flight. Reset selects channel 0 with zero settle time, no pending
// conversion and no result; there is no clearing pass.
module mux_adc_scan_sequencer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [2:0]                           opcode,
  input  wire logic [masseq_pkg::CH_W-1:0]          channel,
  input  wire logic [masseq_pkg::CH_W-1:0]          follow_channel,
  input  wire logic [masseq_pkg::SAMPLE_W-1:0]      adc_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [1:0]                                status,
  output logic                                      result_valid,
  output logic [masseq_pkg::CH_W-1:0]               taken_channel,
  output logic [masseq_pkg::SAMPLE_W-1:0]           result_sample,
  output logic [masseq_pkg::CH_W-1:0]               mux_select,
  output logic                                      start_pulse,
  output logic                                      stop_pulse,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [masseq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [masseq_pkg::COUNT_W-1:0]       cfg_data
);

  masseq_pkg::cmd_t front_cmd;
  masseq_pkg::cmd_t head_cmd;
  logic             head_valid;
  logic             pop;

  // Decode the raw fields into a command with its range checks done.
  masseq_front u_front (
    .opcode         (opcode),
    .channel        (channel),
    .follow_channel (follow_channel),
    .adc_sample     (adc_sample),
    .cmd            (front_cmd)
  );

  // The queue decouples acceptance from execution.
  masseq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // The back end owns all sequencer state and the result register.
  masseq_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .result_valid   (result_valid),
    .taken_channel  (taken_channel),
    .result_sample  (result_sample),
    .mux_select     (mux_select),
    .start_pulse    (start_pulse),
    .stop_pulse     (stop_pulse)
  );

endmodule

`default_nettype wire

FILE: tb/masseq_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the result items of the scan sequencer.
package masseq_tb_pkg;
  import masseq_pkg::*;

  localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef struct {
    status_t             status;
    logic                valid;
    logic [CH_W-1:0]     rch;
    logic [SAMPLE_W-1:0] rsmp;
    logic [CH_W-1:0]     mux;
    logic                start;
    logic                stop;
  } scan_result_t;

  class scan_scoreboard;
    logic [COUNT_W-1:0]  settle_limit;
    logic [COUNT_W-1:0]  timeout_limit;
    logic [CH_W-1:0]     sel_ch;
    logic [COUNT_W-1:0]  settle_count;
    bit                  conv_active;
    logic [CH_W-1:0]     conv_ch;
    logic [CH_W-1:0]     presel_ch;
    logic [COUNT_W-1:0]  conv_count;
    bit                  result_held;
    logic [CH_W-1:0]     held_ch;
    logic [SAMPLE_W-1:0] held_sample;
    scan_result_t        expected_results[$];
    int unsigned         errors;

    function new();
      settle_limit  = '0;
      timeout_limit = TIMEOUT_RESET;
      sel_ch        = '0;
      settle_count  = '0;
      conv_active   = 1'b0;
      conv_ch       = '0;
      presel_ch     = '0;
      conv_count    = '0;
      result_held   = 1'b0;
      held_ch       = '0;
      held_sample   = '0;
      errors        = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [COUNT_W-1:0] value);
      case (idx)
        REG_SETTLE_TICKS: settle_limit = value;
        REG_CONV_TIMEOUT: timeout_limit = value;
        default: ;
      endcase
    endfunction

    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function void select_channel(logic [CH_W-1:0] ch);
      sel_ch       = ch;
      settle_count = '0;
    endfunction

    // Applies one accepted item to the predicted state and queues its result.
    function void note_item(logic [2:0] op, logic [CH_W-1:0] ch, logic [CH_W-1:0] nxt,
                            logic [SAMPLE_W-1:0] smp);
      scan_result_t r;
      r.status = ST_OK;
      r.valid  = 1'b0;
      r.rch    = '0;
      r.rsmp   = '0;
      r.start  = 1'b0;
      r.stop   = 1'b0;
      case (op)
        OPC_TICK: begin
          settle_count = bump(settle_count);
          if (conv_active) conv_count = bump(conv_count);
        end
        OPC_PREPARE: begin
          if (int'(ch) >= CHANNELS) r.status = ST_INVALID;
          else if (sel_ch != ch) select_channel(ch);
        end
        OPC_START: begin
          if (int'(ch) >= CHANNELS || int'(nxt) >= CHANNELS) begin
            r.status = ST_INVALID;
          end else if (conv_active || result_held) begin
            r.status = ST_BUSY;
          end else begin
            if (sel_ch != ch) select_channel(ch);
            if (settle_count < settle_limit) begin
              r.status = ST_BUSY;
            end else begin
              conv_ch     = ch;
              presel_ch   = nxt;
              conv_count  = '0;
              conv_active = 1'b1;
              r.start     = 1'b1;
            end
          end
        end
        OPC_DONE: begin
          if (conv_active) begin
            held_sample = smp & SAMPLE_MASK;
            held_ch     = conv_ch;
            select_channel(presel_ch);
            conv_active = 1'b0;
            result_held = 1'b1;
          end
        end
        OPC_TAKE: begin
          if (result_held) begin
            r.valid     = 1'b1;
            r.rch       = held_ch;
            r.rsmp      = held_sample;
            result_held = 1'b0;
          end else if (conv_active && conv_count >= timeout_limit) begin
            conv_active = 1'b0;
            r.stop      = 1'b1;
            r.status    = ST_TIMEOUT;
          end else begin
            r.status = ST_BUSY;
          end
        end
        default: ;
      endcase
      r.mux = sel_ch;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(logic [1:0] status, logic valid, logic [CH_W-1:0] rch,
                      logic [SAMPLE_W-1:0] rsmp, logic [CH_W-1:0] mux,
                      logic start, logic stop);
      scan_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result item arrived with no item waiting for it");
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (valid !== want.valid)
          report_mismatch($sformatf("result_valid %0b, expected %0b", valid, want.valid));
        if (rch !== want.rch)
          report_mismatch($sformatf("taken_channel %0d, expected %0d", rch, want.rch));
        if (rsmp !== want.rsmp)
          report_mismatch($sformatf("result_sample %0h, expected %0h", rsmp, want.rsmp));
        if (mux !== want.mux)
          report_mismatch($sformatf("mux_select %0d, expected %0d", mux, want.mux));
        if (start !== want.start)
          report_mismatch($sformatf("start_pulse %0b, expected %0b", start, want.start));
        if (stop !== want.stop)
          report_mismatch($sformatf("stop_pulse %0b, expected %0b", stop, want.stop));
      end
    endtask
  endclass

endpackage

FILE: tb/mux_adc_scan_sequencer_test.sv
// Testbench top: drives the scan sequencer with scan sequences and checks every result item.
module mux_adc_scan_sequencer_test;
  import masseq_pkg::*;
  import masseq_tb_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  localparam int LIMIT_CYCLES = 100000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASES       = 4;
  localparam int PHASE_ITEMS  = 175;
  localparam int LAST_ITEMS   = 50;
  localparam int DRAIN_CYCLES = 4;

  // Opcodes above take have no name in the package and act as no-ops.
  localparam logic [2:0] OPC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OPC_SPARE_LAST  = 3'd7;

  // Register settings of the random phases. Short settle and timeout values let the
  // scan sequences hit both the not-yet-settled and the timed-out paths often.
  localparam int SETTLE_TAB  [PHASES] = '{0, 3, 1, 2};
  localparam int TIMEOUT_TAB [PHASES] = '{1, 2, 8, 1000};

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [2:0]          opcode         = '0;
  logic [CH_W-1:0]     channel        = '0;
  logic [CH_W-1:0]     follow_channel = '0;
  logic [SAMPLE_W-1:0] adc_sample     = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [1:0]          status;
  logic                result_valid;
  logic [CH_W-1:0]     taken_channel;
  logic [SAMPLE_W-1:0] result_sample;
  logic [CH_W-1:0]     mux_select;
  logic                start_pulse;
  logic                stop_pulse;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [COUNT_W-1:0]  cfg_data       = '0;

  // Knobs shared between the stimulus process and the receiver process.
  bit sender_idles    = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_request    = 1'b0;
  int items_sent      = 0;

  scan_scoreboard sb = new();

  mux_adc_scan_sequencer u_top (.*);

  always #HALF_PERIOD clk = ~clk;

  // All handshakes are observed at the rising edge, where the stimulus set at the
  // previous falling edge is stable. A result is checked before the item accepted at
  // the same edge is noted, so the oldest expectation is always the one compared.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result(status, result_valid, taken_channel, result_sample,
                        mux_select, start_pulse, stop_pulse);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready)
        sb.note_item(opcode, channel, follow_channel, adc_sample);
    end
  end

  // The receiver takes results whenever it is not stalling. Stalls come in short
  // random bursts, and once the stimulus asks for it the receiver holds off for a
  // long stretch so that the command queue fills and the input side is stalled too.
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // A run that hangs on a handshake ends here.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [CH_W-1:0] any_channel();
    return CH_W'($urandom_range(0, CHANNELS - 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] any_sample();
    return SAMPLE_W'($urandom);
  endfunction

  // Offers one item, starting at a falling edge, and returns at the falling edge
  // after it was accepted. Valid is lowered only when an idle burst follows, so a
  // back-to-back item keeps valid high without a second assignment in one step.
  task automatic send_item(input logic [2:0] op, input logic [CH_W-1:0] ch,
                           input logic [CH_W-1:0] nxt, input logic [SAMPLE_W-1:0] smp);
    in_valid       <= 1'b1;
    opcode         <= op;
    channel        <= ch;
    follow_channel <= nxt;
    adc_sample     <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(OPC_TICK, any_channel(), any_channel(), any_sample());
  endtask

  // Noise covers every opcode, the spare ones included, with arbitrary fields.
  task automatic send_noise(input int n);
    repeat (n) send_item(3'($urandom_range(0, OPC_SPARE_LAST)), any_channel(),
                         any_channel(), any_sample());
  endtask

  // Lowers valid and waits until every expected result has been taken, so that
  // the block is idle and the registers may be written.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Writes both registers back to back on the configuration channel.
  task automatic program_regs(input logic [COUNT_W-1:0] settle,
                              input logic [COUNT_W-1:0] tmo);
    cfg_reg_t           regs[2];
    logic [COUNT_W-1:0] values[2];
    regs[0]   = REG_SETTLE_TICKS;
    regs[1]   = REG_CONV_TIMEOUT;
    values[0] = settle;
    values[1] = tmo;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= values[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One scan of a channel as firmware would issue it: optional prepare, settling
  // ticks, start, conversion ticks, then adc done and take in one of a few orders.
  // Some scans take before done so that busy and timeout paths are exercised.
  task automatic run_scan(input int settle, input int tmo);
    logic [CH_W-1:0] ch;
    logic [CH_W-1:0] nxt;
    int              span;
    int              pick;
    ch   = any_channel();
    nxt  = ($urandom_range(0, 1) == 1) ? ch + 1'b1 : any_channel();
    span = (tmo < 12) ? tmo : 12;
    if ($urandom_range(0, 2) == 0)
      send_item(OPC_PREPARE, ch, any_channel(), any_sample());
    send_ticks($urandom_range(0, settle + 2));
    send_item(OPC_START, ch, nxt, any_sample());
    if ($urandom_range(0, 4) == 0)
      send_item(OPC_START, any_channel(), any_channel(), any_sample());
    // If the start was refused for settling, wait out the settle time and retry.
    if (!sb.conv_active && !sb.result_held) begin
      send_ticks(settle);
      send_item(OPC_START, ch, nxt, any_sample());
    end
    send_ticks($urandom_range(0, span + 2));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      send_item(OPC_DONE, any_channel(), any_channel(), any_sample());
      send_ticks($urandom_range(0, 2));
      send_item(OPC_TAKE, any_channel(), any_channel(), any_sample());
      if ($urandom_range(0, 3) == 0)
        send_item(OPC_TAKE, any_channel(), any_channel(), any_sample());
    end else if (pick < 9) begin
      send_item(OPC_TAKE, any_channel(), any_channel(), any_sample());
      send_item(OPC_DONE, any_channel(), any_channel(), any_sample());
    end else begin
      send_item(OPC_TAKE, any_channel(), any_channel(), any_sample());
      send_item(OPC_TAKE, any_channel(), any_channel(), any_sample());
    end
  endtask

  initial begin
    int phase_end;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset settings: settle time zero, timeout 1000.
    // A take with nothing pending is busy, and adc done with no conversion is ignored.
    send_item(OPC_TAKE, 3'd0, 3'd0, 12'h000);
    send_item(OPC_TICK, 3'd7, 3'd7, 12'hFFF);
    send_item(OPC_DONE, 3'd0, 3'd0, 12'hFFF);
    send_item(OPC_SPARE_FIRST, any_channel(), any_channel(), any_sample());
    send_item(OPC_SPARE_LAST, any_channel(), any_channel(), any_sample());
    // Preparing the channel already selected leaves the settle count running.
    send_item(OPC_PREPARE, 3'd0, 3'd7, 12'h000);
    send_item(OPC_PREPARE, 3'd7, 3'd0, 12'h000);
    // Start on the top channel, then a second start and an early take are both busy.
    send_item(OPC_START, 3'd7, 3'd0, 12'h000);
    send_item(OPC_START, 3'd7, 3'd0, 12'h000);
    send_item(OPC_TAKE, 3'd0, 3'd0, 12'h000);
    send_item(OPC_DONE, 3'd5, 3'd5, 12'hFFF);
    // A start while the result is still unread is refused.
    send_item(OPC_START, 3'd2, 3'd3, 12'h000);
    send_item(OPC_TAKE, 3'd0, 3'd0, 12'h000);
    // Adc done restarts the settle time even when the preselect equals the selection.
    send_item(OPC_START, 3'd3, 3'd3, 12'h000);
    send_item(OPC_DONE, 3'd0, 3'd0, 12'h000);
    send_item(OPC_TAKE, 3'd7, 3'd7, 12'hFFF);
    drain();

    // Timeout register zero: any active conversion times out at the next take.
    // A settle time of two makes the first starts wait on settling.
    program_regs(16'd2, 16'd0);
    send_item(OPC_START, 3'd5, 3'd6, 12'h000);
    send_item(OPC_TICK, 3'd0, 3'd0, 12'h000);
    send_item(OPC_START, 3'd5, 3'd6, 12'h000);
    send_item(OPC_TICK, 3'd0, 3'd0, 12'h000);
    send_item(OPC_START, 3'd5, 3'd6, 12'h000);
    send_item(OPC_TAKE, 3'd0, 3'd0, 12'h000);
    send_item(OPC_DONE, 3'd0, 3'd0, 12'hFFF);
    send_item(OPC_TAKE, 3'd0, 3'd0, 12'h000);

    // Random phases, each under its own register setting. The second phase opens
    // with the long receiver hold-off while the scans keep coming.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      program_regs(SETTLE_TAB[p], TIMEOUT_TAB[p]);
      if (p == 1) hold_request = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 3));
        run_scan(SETTLE_TAB[p], TIMEOUT_TAB[p]);
      end
    end

    // Last part, with no idling on either side, so items and results run back to
    // back under a short settle time and timeout.
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    drain();
    program_regs(16'd1, 16'd4);
    phase_end = items_sent + LAST_ITEMS;
    while (items_sent < phase_end) run_scan(1, 4);
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
